// ===== design/amu_pkg.sv =====
// Shared types, codes and the step sequence table of the affine matrix unit.
`default_nettype none
package amu_pkg;

  localparam int QUO_BITS = 34;
  localparam int CNT_W    = 6;
  localparam int STEP_W   = 5;

  typedef enum logic [1:0] {
    REQ_XFORM   = 2'd0,
    REQ_COMPOSE = 2'd1,
    REQ_LOAD    = 2'd2,
    REQ_INVERT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DWAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_ACC  = 3'd0,
    K_RND  = 3'd1,
    K_SAVE = 3'd2,
    K_DIV  = 3'd3,
    K_END  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_M11, S_M12, S_M21, S_M22, S_MTX, S_MTY,
    S_B11, S_B12, S_B21, S_B22, S_BTX, S_BTY,
    S_PX, S_PY
  } src_t;

  typedef enum logic [3:0] {
    D_N11, D_N12, D_N21, D_N22, D_NTX, D_NTY,
    D_MX, D_MY, D_DET, D_CX, D_CY
  } dst_t;

  typedef struct packed {
    kind_t kind;
    logic  mul_en;
    src_t  ma;
    src_t  mb;
    logic  acc_clr;
    logic  acc_p;
    logic  acc_neg;
    logic  acc_t;
    src_t  tsel;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic capture;
    logic exec;
    logic div_start;
    logic dwrite;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic sing;
    logic div_done;
  } status_t;

  function automatic uop_t plain_uop(input kind_t kind, input dst_t dst);
    uop_t u;
    u = '{kind: kind, mul_en: 1'b0, ma: S_M11, mb: S_M11, acc_clr: 1'b0, acc_p: 1'b0,
          acc_neg: 1'b0, acc_t: 1'b0, tsel: S_M11, dst: dst};
    return u;
  endfunction

  // one sum of two products plus optional shifted term, in four steps
  function automatic uop_t lin_uop(input logic [1:0] k, input src_t u, input src_t a,
                                   input src_t v, input src_t b, input logic use_t,
                                   input src_t t, input logic neg, input kind_t last,
                                   input dst_t dst);
    uop_t o;
    o = plain_uop(K_ACC, dst);
    unique case (k)
      2'd0: begin
        o.mul_en = 1'b1; o.ma = u; o.mb = a;
      end
      2'd1: begin
        o.mul_en = 1'b1; o.ma = v; o.mb = b; o.acc_clr = 1'b1; o.acc_p = 1'b1;
      end
      2'd2: begin
        o.acc_p = 1'b1; o.acc_neg = neg; o.acc_t = use_t; o.tsel = t;
      end
      default: o.kind = last;
    endcase
    return o;
  endfunction

  function automatic uop_t uop_f(input req_t req, input logic [STEP_W-1:0] step);
    uop_t o;
    logic [2:0] ln;
    logic [1:0] k;
    ln = step[4:2];
    k  = step[1:0];
    o  = plain_uop(K_END, D_N11);
    unique case (req)
      REQ_XFORM: begin
        if (step < 5'd8) begin
          if (ln == 3'd0) o = lin_uop(k, S_PX, S_M11, S_PY, S_M21, 1'b1, S_MTX, 1'b0, K_RND, D_MX);
          else            o = lin_uop(k, S_PX, S_M12, S_PY, S_M22, 1'b1, S_MTY, 1'b0, K_RND, D_MY);
        end
      end
      REQ_COMPOSE: begin
        if (step < 5'd24) begin
          unique case (ln)
            3'd0: o = lin_uop(k, S_M11, S_B11, S_M12, S_B21, 1'b0, S_BTX, 1'b0, K_RND, D_N11);
            3'd1: o = lin_uop(k, S_M11, S_B12, S_M12, S_B22, 1'b0, S_BTX, 1'b0, K_RND, D_N12);
            3'd2: o = lin_uop(k, S_M21, S_B11, S_M22, S_B21, 1'b0, S_BTX, 1'b0, K_RND, D_N21);
            3'd3: o = lin_uop(k, S_M21, S_B12, S_M22, S_B22, 1'b0, S_BTX, 1'b0, K_RND, D_N22);
            3'd4: o = lin_uop(k, S_MTX, S_B11, S_MTY, S_B21, 1'b1, S_BTX, 1'b0, K_RND, D_NTX);
            default: o = lin_uop(k, S_MTX, S_B12, S_MTY, S_B22, 1'b1, S_BTY, 1'b0, K_RND, D_NTY);
          endcase
        end
      end
      REQ_LOAD: o = plain_uop(K_END, D_N11);
      default: begin
        if (step < 5'd12) begin
          unique case (ln)
            3'd0: o = lin_uop(k, S_M11, S_M22, S_M12, S_M21, 1'b0, S_M11, 1'b1, K_SAVE, D_DET);
            3'd1: o = lin_uop(k, S_M21, S_MTY, S_M22, S_MTX, 1'b0, S_M11, 1'b1, K_SAVE, D_CX);
            default: o = lin_uop(k, S_M12, S_MTX, S_M11, S_MTY, 1'b0, S_M11, 1'b1, K_SAVE, D_CY);
          endcase
        end else begin
          unique case (step)
            5'd12: o = plain_uop(K_DIV, D_N11);
            5'd13: o = plain_uop(K_DIV, D_N12);
            5'd14: o = plain_uop(K_DIV, D_N21);
            5'd15: o = plain_uop(K_DIV, D_N22);
            5'd16: o = plain_uop(K_DIV, D_NTX);
            5'd17: o = plain_uop(K_DIV, D_NTY);
            default: o = plain_uop(K_END, D_N11);
          endcase
        end
      end
    endcase
    return o;
  endfunction

  // {sat, value}: clip a rounded magnitude with sign to 32-bit signed
  function automatic logic [32:0] sat_f(input logic neg, input logic [65:0] q);
    logic [65:0] nq;
    nq = -q;
    if (neg) begin
      if (q > 66'd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, nq[31:0]};
    end
    if (q > 66'd2147483647) return {1'b1, 32'h7fff_ffff};
    return {1'b0, q[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== design/affine_2d_matrix_unit_top.sv =====
// Top level of the 2D affine matrix unit: stream ports, controller and datapath.
//  channel | dir | transaction
//  in_*    | in  | request: type in tuser, operand matrix and point in tdata
//  out_*   | out | stored matrix, mapped point, singular and saturated flags
// One request at a time. Invert runs one division per inverse entry on the
// one-bit-per-cycle divider, and none when the determinant is zero.
// Each sum of products runs on one shared 32x32 multiplier and accumulator.
// Reset gives the identity matrix. The result holds while out_tready is low,
// and no new request is taken until it is.
`default_nettype none
module affine_2d_matrix_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // op_a11, op_a12, op_a21, op_a22, op_tx, op_ty, point_x, point_y
  input  wire logic [255:0] in_tdata,
  // req_type
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res_a11, res_a12, res_a21, res_a22, res_tx, res_ty, mapped_x, mapped_y
  output logic [255:0]      out_tdata,
  // singular, saturated
  output logic [1:0]        out_tuser
);
  import amu_pkg::*;

  cmd_t    cmd;
  status_t status;

  amu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  amu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_req    (in_tuser),
    .in_data   (in_tdata),
    .res_data  (out_tdata),
    .singular  (out_tuser[0]),
    .saturated (out_tuser[1])
  );
endmodule
`default_nettype wire

// ===== design/amu_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow and round-half flags.
`default_nettype none
module amu_div #(
  parameter int NW = 96
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [NW-1:0]                 num,
  input  wire logic [63:0]                   den,
  output logic                               done,
  output logic [amu_pkg::QUO_BITS-1:0]       quo,
  output logic                               rnd,
  output logic                               ovf
);
  import amu_pkg::*;

  logic [63:0]          rem_r, rem_nxt;
  logic [QUO_BITS-1:0]  low_r, low_nxt, q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt, ovf_r, ovf_nxt;
  logic [NW-1:0]        hi;
  logic [64:0]          t, dd, td;
  logic                 ge;

  always_comb begin
    hi      = {{QUO_BITS{1'b0}}, num[NW-1:QUO_BITS]};
    dd      = {1'b0, den};
    t       = {rem_r, low_r[QUO_BITS-1]};
    td      = t - dd;
    ge      = t >= dd;
    rem_nxt = rem_r;
    low_nxt = low_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    ovf_nxt = ovf_r;
    done_nxt = 1'b0;
    if (start) begin
      ovf_nxt = hi >= {{(NW-64){1'b0}}, den};
      rem_nxt = hi[63:0];
      low_nxt = num[QUO_BITS-1:0];
      q_nxt   = '0;
      cnt_nxt = CNT_W'(QUO_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? td[63:0] : t[63:0];
      low_nxt = {low_r[QUO_BITS-2:0], 1'b0};
      q_nxt   = {q_r[QUO_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;
  assign rnd  = {rem_r, 1'b0} >= dd;
endmodule
`default_nettype wire

// ===== design/amu_dp.sv =====
// Datapath: matrix state, operand capture, multiplier, accumulator, rounding and divider.
`default_nettype none
module amu_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire amu_pkg::cmd_t     cmd,
  output amu_pkg::status_t       status,
  input  wire logic [1:0]        in_req,
  input  wire logic [255:0]      in_data,
  output logic [255:0]           res_data,
  output logic                   singular,
  output logic                   saturated
);
  import amu_pkg::*;

  localparam int NW = 64 + 2 * FRAC_BITS;

  logic signed [31:0] m_r [6];
  logic signed [31:0] n_r [6];
  logic signed [31:0] b_r [6];
  logic signed [31:0] px_r, py_r, mx_r, my_r;
  req_t               req_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r, acc_nxt, cx_r, cy_r;
  logic [63:0]        det_mag_r;
  logic               det_neg_r, sing_r, sat_r, div_neg_r;
  logic signed [31:0] opa, opb, opt;
  logic signed [63:0] prod;
  logic signed [65:0] pterm, tterm, base;
  logic [65:0]        amag, rq, dq;
  logic [32:0]        rres, dres;
  logic [63:0]        nmag;
  logic               nneg, nsh2;
  logic [NW-1:0]      num;
  logic               dv_done, dv_rnd, dv_ovf;
  logic [QUO_BITS-1:0] dv_q;
  logic signed [65:0] sel66;
  logic signed [31:0] sel32;

  function automatic logic signed [31:0] pick(input src_t s);
    unique case (s)
      S_M11: return m_r[0];
      S_M12: return m_r[1];
      S_M21: return m_r[2];
      S_M22: return m_r[3];
      S_MTX: return m_r[4];
      S_MTY: return m_r[5];
      S_B11: return b_r[0];
      S_B12: return b_r[1];
      S_B21: return b_r[2];
      S_B22: return b_r[3];
      S_BTX: return b_r[4];
      S_BTY: return b_r[5];
      S_PX:  return px_r;
      S_PY:  return py_r;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    opa   = pick(cmd.uop.ma);
    opb   = pick(cmd.uop.mb);
    opt   = pick(cmd.uop.tsel);
    prod  = opa * opb;
    base  = cmd.uop.acc_clr ? 66'sd0 : acc_r;
    pterm = cmd.uop.acc_p ? (cmd.uop.acc_neg ? -{{2{prod_r[63]}}, prod_r}
                                             : {{2{prod_r[63]}}, prod_r}) : 66'sd0;
    tterm = cmd.uop.acc_t ? ($signed({{34{opt[31]}}, opt}) <<< FRAC_BITS) : 66'sd0;
    acc_nxt = base + pterm + tterm;
    amag  = acc_r[65] ? 66'(-acc_r) : 66'(acc_r);
    rq    = (amag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rres  = sat_f(acc_r[65], rq);
    dq    = dv_ovf ? (66'd1 << QUO_BITS) : ({{(66-QUO_BITS){1'b0}}, dv_q} + 66'(dv_rnd));
    dres  = sat_f(div_neg_r, dq);
  end

  // numerator select for the inverse entries
  always_comb begin
    nsh2  = 1'b1;
    sel32 = m_r[3];
    sel66 = cx_r;
    nneg  = 1'b0;
    unique case (cmd.uop.dst)
      D_N11: sel32 = m_r[3];
      D_N12: begin sel32 = m_r[1]; nneg = 1'b1; end
      D_N21: begin sel32 = m_r[2]; nneg = 1'b1; end
      D_N22: sel32 = m_r[0];
      D_NTX: begin nsh2 = 1'b0; sel66 = cx_r; end
      D_NTY: begin nsh2 = 1'b0; sel66 = cy_r; end
      default: nsh2 = 1'b1;
    endcase
    if (nsh2) begin
      nmag = sel32[31] ? 64'(-{32'sd0 + {{32{sel32[31]}}, sel32}}) : {32'd0, sel32};
      nneg = nneg ^ sel32[31];
      num  = {{(NW-64){1'b0}}, nmag} << (2 * FRAC_BITS);
    end else begin
      nmag = sel66[65] ? 64'(-sel66) : sel66[63:0];
      nneg = sel66[65];
      num  = {{(NW-64){1'b0}}, nmag} << FRAC_BITS;
    end
  end

  amu_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (det_mag_r),
    .done  (dv_done),
    .quo   (dv_q),
    .rnd   (dv_rnd),
    .ovf   (dv_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r[0] <= 32'sd1 <<< FRAC_BITS;
      m_r[1] <= '0;
      m_r[2] <= '0;
      m_r[3] <= 32'sd1 <<< FRAC_BITS;
      m_r[4] <= '0;
      m_r[5] <= '0;
      sing_r <= 1'b0;
      sat_r  <= 1'b0;
      mx_r   <= '0;
      my_r   <= '0;
    end else begin
      if (cmd.capture) begin
        sing_r <= 1'b0;
        sat_r  <= 1'b0;
        mx_r   <= '0;
        my_r   <= '0;
      end
      if (cmd.exec && cmd.uop.kind == K_RND) begin
        sat_r <= sat_r | rres[32];
        unique case (cmd.uop.dst)
          D_MX: mx_r <= rres[31:0];
          D_MY: my_r <= rres[31:0];
          default: n_r[cmd.uop.dst[2:0]] <= rres[31:0];
        endcase
      end
      if (cmd.exec && cmd.uop.kind == K_SAVE && cmd.uop.dst == D_DET) sing_r <= acc_r == 66'sd0;
      if (cmd.dwrite) begin
        sat_r <= sat_r | dres[32];
        n_r[cmd.uop.dst[2:0]] <= dres[31:0];
      end
      if (cmd.commit) begin
        if (req_r == REQ_LOAD) m_r <= b_r;
        else if (req_r == REQ_COMPOSE || (req_r == REQ_INVERT && !sing_r)) m_r <= n_r;
      end
    end
    if (cmd.capture) begin
      req_r <= req_t'(in_req);
      for (int i = 0; i < 6; i++) b_r[i] <= in_data[32*i +: 32];
      px_r <= in_data[223:192];
      py_r <= in_data[255:224];
    end
    if (cmd.exec && cmd.uop.mul_en) prod_r <= prod;
    if (cmd.exec && cmd.uop.kind == K_ACC) acc_r <= acc_nxt;
    if (cmd.exec && cmd.uop.kind == K_SAVE) begin
      unique case (cmd.uop.dst)
        D_DET: begin
          det_neg_r <= acc_r[65];
          det_mag_r <= acc_r[65] ? 64'(-acc_r) : acc_r[63:0];
        end
        D_CX: cx_r <= acc_r;
        default: cy_r <= acc_r;
      endcase
    end
    if (cmd.div_start) div_neg_r <= nneg ^ det_neg_r;
  end

  assign status.sing     = sing_r;
  assign status.div_done = dv_done;
  assign res_data  = {my_r, mx_r, m_r[5], m_r[4], m_r[3], m_r[2], m_r[1], m_r[0]};
  assign singular  = sing_r;
  assign saturated = sat_r;
endmodule
`default_nettype wire

// ===== design/amu_ctrl.sv =====
// Controller: request sequencer stepping through the step table, divider waits, output hold.
`default_nettype none
module amu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_req,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output amu_pkg::cmd_t          cmd,
  input  wire amu_pkg::status_t  status
);
  import amu_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  req_t                req_r;
  uop_t                uop;

  assign uop = uop_f(req_r, step_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        priority case (uop.kind)
          K_END: state_nxt = ST_DONE;
          K_DIV: begin
            if (status.sing) step_nxt = step_r + 1'b1;
            else state_nxt = ST_DWAIT;
          end
          default: step_nxt = step_r + 1'b1;
        endcase
      end
      ST_DWAIT: begin
        if (status.div_done) begin
          state_nxt = ST_RUN;
          step_nxt  = step_r + 1'b1;
        end
      end
      default: if (out_tready) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.uop       = uop;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_RUN: begin
        cmd.exec      = uop.kind != K_DIV && uop.kind != K_END;
        cmd.div_start = uop.kind == K_DIV && !status.sing;
        cmd.commit    = uop.kind == K_END;
      end
      ST_DWAIT: cmd.dwrite = status.div_done;
      default: out_tvalid = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      req_r   <= REQ_XFORM;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == ST_IDLE && in_tvalid) req_r <= req_t'(in_req);
    end
  end
endmodule
`default_nettype wire
